// File: hw/rtl/desi_pkg.sv
// Package for the damped Euler substep integrator: widths, register indexes,
// microcode word layout and the control program ROM.
// Depends on nothing; imported by damped_euler_substep_integrator.
package desi_pkg;

  localparam int MAX_SUBSTEPS = 256;
  localparam int CNT_W        = $clog2(MAX_SUBSTEPS + 1);

  localparam int VAL_W   = 32;
  localparam int TIME_W  = 24;
  localparam int DAMP_W  = 17;
  localparam int OPB_W   = TIME_W + 1;
  localparam int PROD_W  = VAL_W + OPB_W;
  localparam int SUM_W   = 43;
  localparam int CFG_W   = 24;

  localparam int IN_W    = 9 * VAL_W + TIME_W;
  localparam int OUT_W   = 6 * VAL_W;
  localparam int POS_LSB = 0;
  localparam int VEL_LSB = 3 * VAL_W;
  localparam int ACC_LSB = 6 * VAL_W;
  localparam int ET_LSB  = 9 * VAL_W;

  localparam logic [TIME_W-1:0] FIXED_STEP_RESET = 24'd83886;
  localparam logic [DAMP_W-1:0] DAMPING_RESET    = 17'd64881;

  typedef enum logic [0:0] {
    REG_FIXED_STEP = 1'b0,
    REG_DAMPING    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_TEST = 2'd1,
    SEQ_LOOP = 2'd2
  } seq_op_t;

  typedef enum logic [1:0] {
    WB_NONE     = 2'd0,
    WB_VEL_ADD  = 2'd1,
    WB_POS_ADD  = 2'd2,
    WB_VEL_DAMP = 2'd3
  } wb_op_t;

  typedef struct packed {
    seq_op_t    seq;
    logic       mul_en;
    logic       mul_vel;
    logic       mul_damp;
    logic [1:0] mul_axis;
    wb_op_t     wb;
    logic [1:0] wb_axis;
  } ucode_t;

  localparam int PROG_LEN = 11;
  localparam int PC_W     = $clog2(PROG_LEN);
  localparam logic [PC_W-1:0] PC_START = '0;
  localparam logic [PC_W-1:0] PC_BODY  = PC_W'(1);
  localparam logic [PC_W-1:0] PC_LAST  = PC_W'(PROG_LEN - 1);

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = '{SEQ_NEXT, 1'b0, 1'b0, 1'b0, AX_X, WB_NONE, AX_X};
    case (pc)
      4'd0:  u = '{SEQ_TEST, 1'b0, 1'b0, 1'b0, AX_X, WB_NONE,     AX_X};
      4'd1:  u = '{SEQ_NEXT, 1'b1, 1'b0, 1'b0, AX_X, WB_NONE,     AX_X};
      4'd2:  u = '{SEQ_NEXT, 1'b1, 1'b0, 1'b0, AX_Y, WB_VEL_ADD,  AX_X};
      4'd3:  u = '{SEQ_NEXT, 1'b1, 1'b0, 1'b0, AX_Z, WB_VEL_ADD,  AX_Y};
      4'd4:  u = '{SEQ_NEXT, 1'b1, 1'b1, 1'b0, AX_X, WB_VEL_ADD,  AX_Z};
      4'd5:  u = '{SEQ_NEXT, 1'b1, 1'b1, 1'b0, AX_Y, WB_POS_ADD,  AX_X};
      4'd6:  u = '{SEQ_NEXT, 1'b1, 1'b1, 1'b0, AX_Z, WB_POS_ADD,  AX_Y};
      4'd7:  u = '{SEQ_NEXT, 1'b1, 1'b1, 1'b1, AX_X, WB_POS_ADD,  AX_Z};
      4'd8:  u = '{SEQ_NEXT, 1'b1, 1'b1, 1'b1, AX_Y, WB_VEL_DAMP, AX_X};
      4'd9:  u = '{SEQ_NEXT, 1'b1, 1'b1, 1'b1, AX_Z, WB_VEL_DAMP, AX_Y};
      4'd10: u = '{SEQ_LOOP, 1'b0, 1'b0, 1'b0, AX_X, WB_VEL_DAMP, AX_Z};
      default: u = '{SEQ_NEXT, 1'b0, 1'b0, 1'b0, AX_X, WB_NONE, AX_X};
    endcase
    return u;
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
    return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    lo = {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};
    if (v > hi) begin
      return {1'b0, {(VAL_W - 1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(VAL_W - 1){1'b0}}};
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

// File: hw/rtl/damped_euler_substep_integrator.sv
// Damped semi-implicit Euler integrator with fixed substeps, microcoded.
// A ROM program drives one shared 32x25 multiplier and a round/add/saturate unit.
// One transaction at a time: a new input is accepted only while idle.
// Each substep is nine multiplies through the single multiplier.
// Synchronous reset clears control and loads the register defaults; no clearing pass.
module damped_euler_substep_integrator
  import desi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos x,y,z; vel x,y,z; accel x,y,z; elapsed_time
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // new_pos x,y,z; new_vel x,y,z
  output logic [OUT_W-1:0]  m_tdata,
  // truncated
  output logic              m_tuser,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  state_t                   state;
  logic [PC_W-1:0]          pc;
  logic [CNT_W-1:0]         cnt;
  logic [TIME_W-1:0]        rem;
  logic [TIME_W-1:0]        step;
  logic [TIME_W-1:0]        fixed_step;
  logic [DAMP_W-1:0]        damping;
  logic signed [VAL_W-1:0]  pos [0:2];
  logic signed [VAL_W-1:0]  vel [0:2];
  logic signed [VAL_W-1:0]  acc [0:2];
  logic signed [PROD_W-1:0] preg;

  ucode_t                   uc;
  logic [TIME_W-1:0]        fs_eff;
  logic                     finish;
  logic                     out_free;
  logic                     emit;
  logic signed [VAL_W-1:0]  mul_a;
  logic [TIME_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] rnd24;
  logic signed [PROD_W-1:0] rnd16;
  logic signed [VAL_W-1:0]  wb_base;
  logic signed [SUM_W-1:0]  wb_sum;
  logic signed [VAL_W-1:0]  wb_res;

  localparam logic signed [PROD_W-1:0] HALF24 = PROD_W'(1) << 23;
  localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) << 15;

  assign uc       = ucode_rom(pc);
  assign s_tready = (state == ST_IDLE);
  assign fs_eff   = (fixed_step == '0) ? TIME_W'(1) : fixed_step;
  assign finish   = (rem == '0) || (cnt == CNT_W'(MAX_SUBSTEPS));
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_RUN) && (uc.seq == SEQ_TEST) && finish && out_free;

  always_comb begin
    mul_a   = uc.mul_vel ? vel[uc.mul_axis] : acc[uc.mul_axis];
    mul_b   = uc.mul_damp ? {{(TIME_W - DAMP_W){1'b0}}, damping} : step;
    rnd24   = (preg + HALF24) >>> 24;
    rnd16   = (preg + HALF16) >>> 16;
    wb_base = (uc.wb == WB_POS_ADD) ? pos[uc.wb_axis] : vel[uc.wb_axis];
    wb_sum  = sext_val(wb_base) + rnd24[SUM_W-1:0];
    wb_res  = sat_val((uc.wb == WB_VEL_DAMP) ? rnd16[SUM_W-1:0] : wb_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step <= FIXED_STEP_RESET;
      damping    <= DAMPING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIXED_STEP: fixed_step <= cfg_data;
        REG_DAMPING:    damping    <= cfg_data[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= PC_START;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RUN;
            pc    <= PC_START;
          end
        end
        ST_RUN: begin
          unique case (uc.seq)
            SEQ_TEST: begin
              if (!finish) begin
                pc <= PC_BODY;
              end else if (out_free) begin
                state <= ST_IDLE;
              end
            end
            SEQ_LOOP: pc <= PC_START;
            default:  pc <= pc + PC_W'(1);
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= s_tdata[POS_LSB + VAL_W*i +: VAL_W];
        vel[i] <= s_tdata[VEL_LSB + VAL_W*i +: VAL_W];
        acc[i] <= s_tdata[ACC_LSB + VAL_W*i +: VAL_W];
      end
      rem <= s_tdata[ET_LSB +: TIME_W];
      cnt <= '0;
    end else if (state == ST_RUN) begin
      if (uc.mul_en) begin
        preg <= mul_a * $signed({1'b0, mul_b});
      end
      case (uc.wb) inside
        WB_VEL_ADD, WB_VEL_DAMP: vel[uc.wb_axis] <= wb_res;
        WB_POS_ADD:              pos[uc.wb_axis] <= wb_res;
        default: ;
      endcase
      case (uc.seq)
        SEQ_TEST: begin
          if (!finish) begin
            step <= (fs_eff < rem) ? fs_eff : rem;
          end else if (out_free) begin
            m_tdata <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
            m_tuser <= (rem != '0);
          end
        end
        SEQ_LOOP: begin
          rem <= rem - step;
          cnt <= cnt + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_LAST) else $error("program counter beyond program");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt <= CNT_W'(MAX_SUBSTEPS)))
    else $error("substep count beyond limit");

  a_step_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && pc != PC_START) |-> (step != '0 && step <= rem))
    else $error("substep length out of range");

  a_out_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RUN && uc.seq == SEQ_TEST))
    else $error("result raised outside final test");

endmodule

// File: tb/sv/damped_euler_substep_integrator_test.sv
`timescale 1ns / 100ps
// Self-checking test of damped_euler_substep_integrator: stream stimulus, configuration
// writes and a cycle-accurate-free predictor of the substep integration, checked per result.
// Depends on desi_pkg and the damped_euler_substep_integrator RTL.
module damped_euler_substep_integrator_test
  import desi_pkg::*;
();

  localparam int     CYCLE_LIMIT = 4000000;
  localparam int     REPORT_MAX  = 10;
  localparam longint Q16_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_MIN     = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [TIME_W-1:0]         elapsed;
    logic [2:0][VAL_W-1:0]     acc;
    logic [2:0][VAL_W-1:0]     vel;
    logic [2:0][VAL_W-1:0]     pos;
  } motion_in_t;

  typedef struct packed {
    logic                      truncated;
    logic [2:0][VAL_W-1:0]     vel;
    logic [2:0][VAL_W-1:0]     pos;
  } motion_out_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_addr = REG_FIXED_STEP;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic [TIME_W-1:0] fixed_step_q = FIXED_STEP_RESET;
  logic [DAMP_W-1:0] damping_q = DAMPING_RESET;
  motion_out_t       predicted_states[$];
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                cycle_count = 0;

  damped_euler_substep_integrator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_q16(input longint x);
    if (x > Q16_MAX) begin
      return Q16_MAX;
    end else if (x < Q16_MIN) begin
      return Q16_MIN;
    end
    return x;
  endfunction

  function automatic longint round_shift(input longint prod, input int sh);
    return (prod + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic motion_out_t integrate_motion(input motion_in_t m);
    longint      p[3];
    longint      v[3];
    longint      a[3];
    int          remaining;
    int          step_max;
    int          step;
    int          substeps;
    motion_out_t r;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(m.pos[i]));
      v[i] = longint'($signed(m.vel[i]));
      a[i] = longint'($signed(m.acc[i]));
    end
    remaining = int'({8'd0, m.elapsed});
    step_max  = (fixed_step_q == '0) ? 1 : int'({8'd0, fixed_step_q});
    substeps  = 0;
    while (remaining > 0 && substeps < MAX_SUBSTEPS) begin
      step = (step_max < remaining) ? step_max : remaining;
      for (int i = 0; i < 3; i++) begin
        v[i] = clamp_q16(v[i] + round_shift(a[i] * longint'(step), 24));
        p[i] = clamp_q16(p[i] + round_shift(v[i] * longint'(step), 24));
        v[i] = clamp_q16(round_shift(v[i] * longint'({15'd0, damping_q}), 16));
      end
      remaining -= step;
      substeps++;
    end
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = VAL_W'(p[i]);
      r.vel[i] = VAL_W'(v[i]);
    end
    r.truncated = (remaining > 0);
    return r;
  endfunction

  function automatic int pick_gap(input int pct);
    if (pct == 0 || $urandom_range(99) >= pct) begin
      return 0;
    end else if ($urandom_range(9) == 0) begin
      return $urandom_range(20, 80);
    end
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [VAL_W-1:0] rand_q16();
    logic [VAL_W-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3, 4: begin
        v = $urandom_range(0, 32'h0003_FFFF);
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic motion_in_t random_motion(input logic [TIME_W-1:0] t);
    motion_in_t m;
    for (int i = 0; i < 3; i++) begin
      m.pos[i] = rand_q16();
      m.vel[i] = rand_q16();
      m.acc[i] = rand_q16();
    end
    m.elapsed = t;
    return m;
  endfunction

  function automatic motion_in_t uniform_motion(input logic [VAL_W-1:0] p,
      input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] a, input logic [TIME_W-1:0] t);
    motion_in_t m;
    for (int i = 0; i < 3; i++) begin
      m.pos[i] = p;
      m.vel[i] = v;
      m.acc[i] = a;
    end
    m.elapsed = t;
    return m;
  endfunction

  function automatic logic [TIME_W-1:0] pick_elapsed();
    longint span;
    longint step_max;
    int     k;
    int     r;
    step_max = (fixed_step_q == '0) ? 1 : longint'({40'd0, fixed_step_q});
    r = $urandom_range(99);
    if (r < 4) begin
      return '0;
    end else if (r < 7) begin
      return TIME_W'($urandom);
    end
    k = (r < 11) ? $urandom_range(250, 300) : $urandom_range(1, 6);
    span = step_max * (k - 1) + longint'($urandom_range(1, int'(step_max)));
    if (span > 64'h00FF_FFFF) begin
      span = 64'h00FF_FFFF;
    end
    return TIME_W'(span);
  endfunction

  task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIXED_STEP) begin
      fixed_step_q = value[TIME_W-1:0];
    end else begin
      damping_q = value[DAMP_W-1:0];
    end
    @(posedge clk);
  endtask

  task automatic send_motion(input motion_in_t m);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= m;
    do @(posedge clk); while (!s_tready);
    predicted_states.push_back(integrate_motion(m));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (predicted_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_field(input string name, input int axis,
      input logic [VAL_W-1:0] want, input logic [VAL_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_MAX) begin
        $display("%0t: %s[%0d] mismatch: expected %h, got %h", $realtime, name, axis, want, got);
      end
    end
  endtask

  initial begin : result_monitor
    int          stall_left;
    motion_out_t want;
    motion_out_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) begin
        got = {m_tuser, m_tdata};
        if (predicted_states.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("%0t: result with no expectation: %h", $realtime, got);
          end
        end else begin
          want = predicted_states.pop_front();
          for (int i = 0; i < 3; i++) begin
            report_field("new_position", i, want.pos[i], got.pos[i]);
            report_field("new_velocity", i, want.vel[i], got.vel[i]);
          end
          report_field("truncated", 0, VAL_W'(want.truncated), VAL_W'(got.truncated));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        stall_left = pick_gap(100) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic test_zero_elapsed();
    send_motion(uniform_motion(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
    send_motion(uniform_motion(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
    drain_results();
  endtask

  task automatic test_single_and_partial_step();
    send_motion(random_motion(fixed_step_q));
    send_motion(random_motion(TIME_W'(1)));
    send_motion(random_motion(fixed_step_q * 3 + TIME_W'(17)));
    drain_results();
  endtask

  task automatic test_saturation_extremes();
    send_motion(uniform_motion(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF));
    send_motion(uniform_motion(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF));
    send_motion(uniform_motion(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h80_0000));
    send_motion(random_motion(24'hFF_FFFF));
    drain_results();
  endtask

  task automatic test_substep_limit();
    write_register(REG_FIXED_STEP, 24'd1);
    send_motion(random_motion(TIME_W'(MAX_SUBSTEPS)));
    send_motion(random_motion(TIME_W'(MAX_SUBSTEPS + 1)));
    drain_results();
    write_register(REG_FIXED_STEP, '0);
    send_motion(random_motion(TIME_W'(MAX_SUBSTEPS)));
    send_motion(random_motion(24'hFF_FFFF));
    drain_results();
    write_register(REG_FIXED_STEP, 24'hFF_FFFF);
    send_motion(random_motion(24'hFF_FFFF));
    drain_results();
  endtask

  task automatic test_damping_range();
    write_register(REG_FIXED_STEP, FIXED_STEP_RESET);
    write_register(REG_DAMPING, '0);
    send_motion(random_motion(fixed_step_q * 2 + TIME_W'(5)));
    drain_results();
    write_register(REG_DAMPING, CFG_W'(17'h1_0000));
    send_motion(random_motion(fixed_step_q * 4));
    drain_results();
    // upper data bits lie outside the register and must be masked off
    write_register(REG_DAMPING, 24'hFF_FFFF);
    send_motion(uniform_motion(32'h0001_0000, 32'h0100_0000, 32'h0000_0000, 24'hFF_FFFF));
    send_motion(random_motion(fixed_step_q * 6));
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] step_val;
    logic [DAMP_W-1:0] damp_val;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0: step_val = CFG_W'($urandom_range(1, 255));
        1: step_val = CFG_W'($urandom_range(256, 65535));
        2: step_val = CFG_W'($urandom_range(65536, 24'hFF_FFFF));
        default: step_val = FIXED_STEP_RESET;
      endcase
      damp_val = ($urandom_range(3) == 0) ? DAMP_W'($urandom) : DAMP_W'($urandom_range(60000, 65536));
      write_register(REG_FIXED_STEP, step_val);
      write_register(REG_DAMPING, {7'($urandom), damp_val});
      send_idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 70);
      recv_idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(10, 70);
      for (int n = 0; n < 48; n++) begin
        send_motion(random_motion(pick_elapsed()));
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 30;
    test_zero_elapsed();
    test_single_and_partial_step();
    test_saturation_extremes();
    test_substep_limit();
    test_damping_range();
    test_random_phases();
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
